// ----- design/owm_pkg.sv -----
// owm_pkg: shared types and constants for the 1-Wire master slot timer.
// Holds command codes, register indexes, reset values and the word structs.
// No dependencies.
package owm_pkg;

  // Timing register width and count, index width and default tick counter width
  localparam int REG_W      = 10;
  localparam int NUM_REGS   = 8;
  localparam int CFG_IDX_W  = 4;
  localparam int TICK_BITS_DEF = 10;

  // Command codes
  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_RESET = 3'd1;
  localparam logic [2:0] OP_WBIT  = 3'd2;
  localparam logic [2:0] OP_RBIT  = 3'd3;
  localparam logic [2:0] OP_WBYTE = 3'd4;
  localparam logic [2:0] OP_RBYTE = 3'd5;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WRITE_ONE_LOW      = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WRITE_ZERO_LOW     = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_READ_LOW           = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_READ_SAMPLE_AT     = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_LENGTH        = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW          = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_SAMPLE_AT = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_RESET_LENGTH       = 4'd7;

  // Reset values of the timing registers
  localparam logic [REG_W-1:0] RST_WRITE_ONE_LOW      = 10'd6;
  localparam logic [REG_W-1:0] RST_WRITE_ZERO_LOW     = 10'd60;
  localparam logic [REG_W-1:0] RST_READ_LOW           = 10'd6;
  localparam logic [REG_W-1:0] RST_READ_SAMPLE_AT     = 10'd15;
  localparam logic [REG_W-1:0] RST_SLOT_LENGTH        = 10'd70;
  localparam logic [REG_W-1:0] RST_RESET_LOW          = 10'd480;
  localparam logic [REG_W-1:0] RST_PRESENCE_SAMPLE_AT = 10'd550;
  localparam logic [REG_W-1:0] RST_RESET_LENGTH       = 10'd960;

  // Timing register set as seen by the slot engine
  typedef struct packed {
    logic [REG_W-1:0] write_one_low;
    logic [REG_W-1:0] write_zero_low;
    logic [REG_W-1:0] read_low;
    logic [REG_W-1:0] read_sample_at;
    logic [REG_W-1:0] slot_length;
    logic [REG_W-1:0] reset_low;
    logic [REG_W-1:0] presence_sample_at;
    logic [REG_W-1:0] reset_length;
  } timing_t;

  // One result word
  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] result_byte;
    logic       no_presence;
  } res_t;

endpackage

// ----- design/one_wire_master_slot_timer.sv -----
// one_wire_master_slot_timer: 1-Wire master, one input word per timebase tick.
// Pipeline: two register stages; an accepted tick word is held in the input register, then
// passes through the slot logic into the result register.
// Throughput: one word per cycle; only out_stall holds the pipeline back.
// Reset (rst_n low, synchronous): pipeline empty, idle, timing registers at defaults.
// Depends on owm_pkg, owm_cfg_regs and owm_slot_engine.
module one_wire_master_slot_timer import owm_pkg::*; #(
  parameter int TICK_BITS = TICK_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_wdata,
  // tick words in
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [2:0]           in_op,
  input  logic [7:0]           in_data_in,
  input  logic                 in_line_in,
  // result words out
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_drive_low,
  output logic                 out_busy_res,
  output logic                 out_done_res,
  output logic [7:0]           out_result_byte,
  output logic                 out_no_presence
);

  timing_t    timing;
  res_t       res, res_r;
  logic       in_vld_r, out_vld_r;
  logic [2:0] op_r;
  logic [7:0] data_r;
  logic       line_r;
  logic       advance, in_acc;

  owm_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .timing    (timing)
  );

  owm_slot_engine #(.TICK_BITS(TICK_BITS)) u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .op      (op_r),
    .data_in (data_r),
    .line_in (line_r),
    .timing  (timing),
    .res     (res)
  );

  // Handshake: word moves on when the result register is free or draining
  assign advance  = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !advance;
  assign in_acc   = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_acc) begin
      in_vld_r <= 1'b1;
    end else if (advance) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r   <= in_op;
      data_r <= in_data_in;
      line_r <= in_line_in;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_drive_low   = res_r.drive_low;
  assign out_busy_res    = res_r.busy_res;
  assign out_done_res    = res_r.done_res;
  assign out_result_byte = res_r.result_byte;
  assign out_no_presence = res_r.no_presence;

endmodule

// ----- design/owm_cfg_regs.sv -----
// owm_cfg_regs: timing register file behind the plain write port.
// Depends on owm_pkg for indexes, widths and reset values.
module owm_cfg_regs import owm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_wdata,
  output timing_t              timing
);

  timing_t regs_r;

  // Register writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.write_one_low      <= RST_WRITE_ONE_LOW;
      regs_r.write_zero_low     <= RST_WRITE_ZERO_LOW;
      regs_r.read_low           <= RST_READ_LOW;
      regs_r.read_sample_at     <= RST_READ_SAMPLE_AT;
      regs_r.slot_length        <= RST_SLOT_LENGTH;
      regs_r.reset_low          <= RST_RESET_LOW;
      regs_r.presence_sample_at <= RST_PRESENCE_SAMPLE_AT;
      regs_r.reset_length       <= RST_RESET_LENGTH;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WRITE_ONE_LOW:      regs_r.write_one_low      <= cfg_wdata;
        REG_WRITE_ZERO_LOW:     regs_r.write_zero_low     <= cfg_wdata;
        REG_READ_LOW:           regs_r.read_low           <= cfg_wdata;
        REG_READ_SAMPLE_AT:     regs_r.read_sample_at     <= cfg_wdata;
        REG_SLOT_LENGTH:        regs_r.slot_length        <= cfg_wdata;
        REG_RESET_LOW:          regs_r.reset_low          <= cfg_wdata;
        REG_PRESENCE_SAMPLE_AT: regs_r.presence_sample_at <= cfg_wdata;
        REG_RESET_LENGTH:       regs_r.reset_length       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign timing = regs_r;

endmodule

// ----- design/owm_slot_engine.sv -----
// owm_slot_engine: command state and the per-tick slot logic.
// Takes one registered tick word per step and yields the result word.
// Depends on owm_pkg.
module owm_slot_engine import owm_pkg::*; #(
  parameter int TICK_BITS = TICK_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step_en,
  input  logic [2:0] op,
  input  logic [7:0] data_in,
  input  logic       line_in,
  input  timing_t    timing,
  output res_t       res
);

  // Common compare width covering both the counter and the registers
  localparam int CMP_W = ((TICK_BITS > REG_W) ? TICK_BITS : REG_W) + 1;

  logic [TICK_BITS-1:0] slot_tick_r, slot_tick_nxt;
  logic [2:0]           bit_index_r, bit_index_nxt;
  logic [7:0]           shift_data_r, shift_data_nxt;
  logic [2:0]           active_cmd_r, active_cmd_nxt;
  logic                 presence_r, presence_nxt;

  logic                 start;
  logic [2:0]           cmd;
  logic [TICK_BITS-1:0] tick;
  logic [2:0]           bidx;
  logic [7:0]           shift, shift_s;
  logic [REG_W-1:0]     low_t, sample_t, len_t;
  logic                 reads;
  logic [CMP_W-1:0]     tick_x, low_x, sample_x, len_x;
  logic                 slot_end, more_slots;

  always_comb begin
    // Command launch only from idle with a real command
    start = (active_cmd_r == OP_NONE) && (op >= OP_RESET) && (op <= OP_RBYTE);
    cmd   = start ? op : active_cmd_r;
    tick  = start ? '0 : slot_tick_r;
    bidx  = start ? 3'd0 : bit_index_r;
    if (start) begin
      case (op)
        OP_WBIT:  shift = {7'd0, |data_in};
        OP_WBYTE: shift = data_in;
        default:  shift = 8'd0;
      endcase
    end else begin
      shift = shift_data_r;
    end

    // Slot timing for this command
    case (cmd)
      OP_RESET: begin
        low_t = timing.reset_low; sample_t = timing.presence_sample_at;
        len_t = timing.reset_length; reads = 1'b1;
      end
      OP_RBIT, OP_RBYTE: begin
        low_t = timing.read_low; sample_t = timing.read_sample_at;
        len_t = timing.slot_length; reads = 1'b1;
      end
      default: begin
        low_t = shift[0] ? timing.write_one_low : timing.write_zero_low;
        sample_t = '0; len_t = timing.slot_length; reads = 1'b0;
      end
    endcase

    tick_x   = CMP_W'(tick);
    low_x    = CMP_W'(low_t);
    sample_x = CMP_W'(sample_t);
    len_x    = CMP_W'(len_t);

    // Line sample
    shift_s = shift;
    if (reads && (tick_x == sample_x)) begin
      if (cmd == OP_RBYTE) shift_s = shift | (8'(line_in) << bidx);
      else                 shift_s = {7'd0, line_in};
    end

    slot_end   = (tick_x + CMP_W'(1) >= len_x) || (&tick);
    more_slots = ((cmd == OP_WBYTE) || (cmd == OP_RBYTE)) && (bidx != 3'd7);

    // Next state and result word
    slot_tick_nxt  = slot_tick_r;
    bit_index_nxt  = bit_index_r;
    shift_data_nxt = shift_data_r;
    active_cmd_nxt = active_cmd_r;
    presence_nxt   = presence_r;
    res            = '0;
    if (cmd != OP_NONE) begin
      res.busy_res   = 1'b1;
      res.drive_low  = tick_x < low_x;
      active_cmd_nxt = cmd;
      bit_index_nxt  = bidx;
      shift_data_nxt = shift_s;
      if (!slot_end) begin
        slot_tick_nxt = tick + TICK_BITS'(1);
      end else if (more_slots) begin
        bit_index_nxt = bidx + 3'd1;
        slot_tick_nxt = '0;
        if (cmd == OP_WBYTE) shift_data_nxt = shift_s >> 1;
      end else begin
        res.done_res = 1'b1;
        case (cmd)
          OP_RESET: presence_nxt = shift_s[0];
          OP_RBIT:  res.result_byte = {7'd0, shift_s[0]};
          OP_RBYTE: res.result_byte = shift_s;
          default: ;
        endcase
        active_cmd_nxt = OP_NONE;
        slot_tick_nxt  = '0;
        bit_index_nxt  = 3'd0;
        shift_data_nxt = 8'd0;
      end
    end
    res.no_presence = presence_nxt;
  end

  // State registers, stepped once per tick word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_tick_r  <= '0;
      bit_index_r  <= 3'd0;
      shift_data_r <= 8'd0;
      active_cmd_r <= OP_NONE;
      presence_r   <= 1'b0;
    end else if (step_en) begin
      slot_tick_r  <= slot_tick_nxt;
      bit_index_r  <= bit_index_nxt;
      shift_data_r <= shift_data_nxt;
      active_cmd_r <= active_cmd_nxt;
      presence_r   <= presence_nxt;
    end
  end

endmodule
